### hdl/fec_playout_buffer_unit_assert.svh
// Assertion macros for the FEC playout buffer.
// Used by the top level only; it needs clk and rst in scope.
`ifndef FEC_PLAYOUT_BUFFER_UNIT_ASSERT_SVH
`define FEC_PLAYOUT_BUFFER_UNIT_ASSERT_SVH

// A condition that must hold at every clock edge out of reset.
`define FPB_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A condition that must hold in the same cycle as its trigger.
`define FPB_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

### hdl/fpb_pkg.sv
// Shared types and codes for the FEC playout buffer.
// No dependencies; imported by fpb_deadline and the top level.
package fpb_pkg;

  localparam logic [1:0] ST_BEAT = 2'd0;
  localparam logic [1:0] ST_SKIP = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;
  localparam logic [1:0] ST_EXH  = 2'd3;

  localparam logic [7:0] CFG_BASE   = 8'd0;
  localparam logic [7:0] CFG_PERIOD = 8'd1;

  localparam logic [31:0] PERIOD_RESET = 32'd20000;

  typedef struct packed {
    logic        mode;
    logic [31:0] header_word;
    logic [63:0] payload_beat;
    logic        packet_end;
    logic [31:0] now_time;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [10:0] frame_number;
    logic [4:0]  beat_index;
    logic [63:0] out_beat;
    logic        run_last;
  } out_item_t;

endpackage

### hdl/fpb_ram.sv
// Generic simple dual-port RAM with registered read.
// One write port, one read port; no dependencies.
module fpb_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/fpb_deadline.sv
// Deadline unit: base + frame * period, saturated to 32 bits.
// One multiplier stage and one add stage; depends on fpb_pkg.
module fpb_deadline
  import fpb_pkg::*;
#(
  parameter int EW = 11
) (
  input  logic          clk,
  input  logic [EW-1:0] frame,
  input  logic [31:0]   base,
  input  logic [19:0]   period,
  output logic [31:0]   deadline
);

  localparam int PW = EW + 20;
  localparam int SW = ((PW > 32) ? PW : 32) + 1;

  logic [PW-1:0] prod;
  logic [SW-1:0] sum;

  assign sum = SW'(base) + SW'(prod);

  always_ff @(posedge clk) begin
    prod <= PW'(frame) * PW'(period);
    if (sum[SW-1:32] != '0) begin
      deadline <= 32'hFFFF_FFFF;
    end else begin
      deadline <= sum[31:0];
    end
  end

endmodule

### hdl/fec_playout_buffer_unit.sv
// FEC playout buffer: in-order frame release with XOR parity repair.
// Depends on fpb_pkg, fpb_ram, fpb_deadline and the assertion header.
//
// Input channel (in_valid/in_stall/in_item) takes packet beats and polls.
// A packet beat is written to the staging buffer when accepted. The last beat
// of a complete packet starts a copy of the staging buffer into its slot,
// during which in_stall is high. A poll reads the valid bits; a missing frame
// that can be repaired is rebuilt one beat per cycle through the XOR unit.
// Release then reads each beat from the store and puts it in the output
// register, one beat at a time. Skip and waiting answers follow the
// valid-bit read; an exhausted answer is given without it.
// The single store read port sets the release rate.
// Output items sit in one output register; while out_stall holds an item,
// a sequencer with another item to emit waits and in_stall stays high.
// After reset the valid bits are swept clear with in_stall high.
// Configuration writes are taken at any time (cfg_ready is always high) and
// the deadline follows a write through the deadline unit's registers.
module fec_playout_buffer_unit
  import fpb_pkg::*;
#(
  parameter int FRAME_SLOTS     = 1024,
  parameter int BEATS_PER_FRAME = 20
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_item,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  `include "fec_playout_buffer_unit_assert.svh"

  localparam int PS  = FRAME_SLOTS / 2;
  localparam int FW  = $clog2(FRAME_SLOTS);
  localparam int PW  = (PS > 1) ? $clog2(PS) : 1;
  localparam int EW  = $clog2(FRAME_SLOTS + 1);
  localparam int IW  = (BEATS_PER_FRAME > 1) ? $clog2(BEATS_PER_FRAME) : 1;
  localparam int CW  = $clog2(BEATS_PER_FRAME + 1);
  localparam int FD  = FRAME_SLOTS * BEATS_PER_FRAME;
  localparam int PD  = PS * BEATS_PER_FRAME;
  localparam int FA  = (FD > 1) ? $clog2(FD) : 1;
  localparam int PA  = (PD > 1) ? $clog2(PD) : 1;

  localparam logic [3:0] S_CLEAR    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_COPY     = 4'd2;
  localparam logic [3:0] S_COPY_END = 4'd3;
  localparam logic [3:0] S_RD1      = 4'd4;
  localparam logic [3:0] S_RD2      = 4'd5;
  localparam logic [3:0] S_DEC      = 4'd6;
  localparam logic [3:0] S_REB      = 4'd7;
  localparam logic [3:0] S_REB_END  = 4'd8;
  localparam logic [3:0] S_RD       = 4'd9;
  localparam logic [3:0] S_EMIT     = 4'd10;
  localparam logic [3:0] S_ONE      = 4'd11;

  logic [3:0]    state;
  logic [FW-1:0] clr_cnt;
  logic [31:0]   base_us;
  logic [19:0]   period_us;
  logic [31:0]   deadline;
  logic [EW-1:0] expected;
  logic [CW-1:0] staged;
  logic          overflow;
  logic [IW-1:0] idx;
  logic [IW-1:0] widx;
  logic          pend_copy;
  logic          pend_reb;
  logic [FW-1:0] slot;
  logic [FA-1:0] slot_base;
  logic          copy_par;
  logic [FA-1:0] ebase;
  logic [FA-1:0] obase;
  logic [PA-1:0] pbase;
  logic [EW-1:0] other;
  logic          other_ok;
  logic          fv_e;
  logic          pv_ok;
  logic [31:0]   now_r;
  logic [1:0]    one_status;
  logic          out_free;
  logic          emit_now;
  logic          in_acc;
  logic          last_idx;
  logic [30:0]   num;
  logic          commit;

  // Store ports
  logic          stg_we;
  logic          stg_re;
  logic [63:0]   stg_rdata;
  logic          frm_we;
  logic [FA-1:0] frm_waddr;
  logic [63:0]   frm_wdata;
  logic          frm_re;
  logic [FA-1:0] frm_raddr;
  logic [63:0]   frm_rdata;
  logic          par_we;
  logic          par_re;
  logic [PA-1:0] par_raddr;
  logic [63:0]   par_rdata;
  logic          fv_we;
  logic [FW-1:0] fv_waddr;
  logic [0:0]    fv_wdata;
  logic [FW-1:0] fv_raddr;
  logic [0:0]    fv_rdata;
  logic          pv_we;
  logic [PW-1:0] pv_waddr;
  logic [0:0]    pv_wdata;
  logic [0:0]    pv_rdata;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign emit_now  = ((state == S_EMIT) || (state == S_ONE)) && out_free;
  assign last_idx  = (idx == IW'(BEATS_PER_FRAME - 1));
  assign other     = expected ^ EW'(1);
  assign other_ok  = (other < EW'(FRAME_SLOTS)) && ((expected >> 1) < EW'(PS));
  assign num       = in_item.header_word[30:0];
  assign commit    = (staged == CW'(BEATS_PER_FRAME - 1)) && !overflow &&
                     (in_item.header_word[31] ? (num < 31'(PS))
                                              : (num < 31'(FRAME_SLOTS)));

  fpb_deadline #(.EW(EW)) u_deadline (
    .clk      (clk),
    .frame    (expected),
    .base     (base_us),
    .period   (period_us),
    .deadline (deadline)
  );

  // Staging buffer, written one beat per accepted packet beat while it has room.
  assign stg_we = in_acc && !in_item.mode && (staged < CW'(BEATS_PER_FRAME));
  assign stg_re = (state == S_COPY);

  fpb_ram #(.WIDTH(64), .DEPTH(BEATS_PER_FRAME)) u_staging (
    .clk   (clk),
    .we    (stg_we),
    .waddr (staged[IW-1:0]),
    .wdata (in_item.payload_beat),
    .re    (stg_re),
    .raddr (idx),
    .rdata (stg_rdata)
  );

  always_comb begin
    frm_we    = 1'b0;
    frm_waddr = slot_base + FA'(widx);
    frm_wdata = stg_rdata;
    if (pend_copy && !copy_par) begin
      frm_we = 1'b1;
    end else if (pend_reb) begin
      frm_we    = 1'b1;
      frm_waddr = ebase + FA'(widx);
      frm_wdata = par_rdata ^ frm_rdata;
    end
  end

  assign frm_re    = (state == S_REB) || (state == S_RD);
  assign frm_raddr = (state == S_REB) ? (obase + FA'(idx)) : (ebase + FA'(idx));

  fpb_ram #(.WIDTH(64), .DEPTH(FD)) u_frame_store (
    .clk   (clk),
    .we    (frm_we),
    .waddr (frm_waddr),
    .wdata (frm_wdata),
    .re    (frm_re),
    .raddr (frm_raddr),
    .rdata (frm_rdata)
  );

  assign par_we    = pend_copy && copy_par;
  assign par_re    = (state == S_REB);
  assign par_raddr = pbase + PA'(idx);

  fpb_ram #(.WIDTH(64), .DEPTH(PD)) u_parity_store (
    .clk   (clk),
    .we    (par_we),
    .waddr (PA'(slot_base) + PA'(widx)),
    .wdata (stg_rdata),
    .re    (par_re),
    .raddr (par_raddr),
    .rdata (par_rdata)
  );

  // Valid bits: cleared by the sweep, set on commit or repair.
  always_comb begin
    fv_we    = 1'b0;
    fv_waddr = slot;
    fv_wdata = 1'b1;
    pv_we    = 1'b0;
    pv_waddr = slot[PW-1:0];
    pv_wdata = 1'b1;
    case (state)
      S_CLEAR: begin
        fv_we    = 1'b1;
        fv_waddr = clr_cnt;
        fv_wdata = 1'b0;
        pv_we    = (clr_cnt < FW'(PS));
        pv_waddr = clr_cnt[PW-1:0];
        pv_wdata = 1'b0;
      end
      S_COPY_END: begin
        fv_we = !copy_par;
        pv_we = copy_par;
      end
      S_REB_END: begin
        fv_we    = 1'b1;
        fv_waddr = expected[FW-1:0];
      end
      default: begin
      end
    endcase
  end

  assign fv_raddr = (state == S_RD1) ? expected[FW-1:0] : other[FW-1:0];

  fpb_ram #(.WIDTH(1), .DEPTH(FRAME_SLOTS)) u_frame_valid (
    .clk   (clk),
    .we    (fv_we),
    .waddr (fv_waddr),
    .wdata (fv_wdata),
    .re    (1'b1),
    .raddr (fv_raddr),
    .rdata (fv_rdata)
  );

  fpb_ram #(.WIDTH(1), .DEPTH(PS)) u_parity_valid (
    .clk   (clk),
    .we    (pv_we),
    .waddr (pv_waddr),
    .wdata (pv_wdata),
    .re    (1'b1),
    .raddr (PW'(expected >> 1)),
    .rdata (pv_rdata)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      base_us   <= '0;
      period_us <= PERIOD_RESET[19:0];
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_BASE) begin
        base_us <= cfg_data;
      end else if (cfg_index == CFG_PERIOD) begin
        period_us <= cfg_data[19:0];
      end
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    pend_copy <= (state == S_COPY);
    pend_reb  <= (state == S_REB);
    widx      <= idx;
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      expected  <= '0;
      staged    <= '0;
      overflow  <= 1'b0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit_now) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + FW'(1);
          if (clr_cnt == FW'(FRAME_SLOTS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          idx <= '0;
          if (in_acc && !in_item.mode) begin
            if (in_item.packet_end) begin
              staged    <= '0;
              overflow  <= 1'b0;
              slot      <= num[FW-1:0];
              slot_base <= FA'(num[FW-1:0] * BEATS_PER_FRAME);
              copy_par  <= in_item.header_word[31];
              if (commit) begin
                state <= S_COPY;
              end
            end else if (staged < CW'(BEATS_PER_FRAME)) begin
              staged <= staged + CW'(1);
            end else begin
              overflow <= 1'b1;
            end
          end else if (in_acc) begin
            now_r <= in_item.now_time;
            ebase <= FA'(expected[FW-1:0] * BEATS_PER_FRAME);
            obase <= FA'(other[FW-1:0] * BEATS_PER_FRAME);
            pbase <= PA'((expected >> 1) * BEATS_PER_FRAME);
            if (expected == EW'(FRAME_SLOTS)) begin
              one_status <= ST_EXH;
              state      <= S_ONE;
            end else begin
              state <= S_RD1;
            end
          end
        end
        S_COPY: begin
          if (last_idx) begin
            state <= S_COPY_END;
          end else begin
            idx <= idx + IW'(1);
          end
        end
        S_COPY_END: begin
          state <= S_IDLE;
        end
        S_RD1: begin
          state <= S_RD2;
        end
        S_RD2: begin
          fv_e  <= fv_rdata[0];
          pv_ok <= pv_rdata[0];
          state <= S_DEC;
        end
        S_DEC: begin
          if (fv_e) begin
            state <= S_RD;
          end else if (other_ok && pv_ok && fv_rdata[0]) begin
            state <= S_REB;
          end else begin
            one_status <= (now_r >= deadline) ? ST_SKIP : ST_WAIT;
            state      <= S_ONE;
          end
        end
        S_REB: begin
          if (last_idx) begin
            state <= S_REB_END;
          end else begin
            idx <= idx + IW'(1);
          end
        end
        S_REB_END: begin
          idx   <= '0;
          state <= S_RD;
        end
        S_RD: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            out_item.status       <= ST_BEAT;
            out_item.frame_number <= 11'(expected);
            out_item.beat_index   <= 5'(idx);
            out_item.out_beat     <= frm_rdata;
            out_item.run_last     <= last_idx;
            if (last_idx) begin
              expected <= expected + EW'(1);
              state    <= S_IDLE;
            end else begin
              idx   <= idx + IW'(1);
              state <= S_RD;
            end
          end
        end
        S_ONE: begin
          if (out_free) begin
            out_item.status       <= one_status;
            out_item.frame_number <= 11'(expected);
            out_item.beat_index   <= '0;
            out_item.out_beat     <= '0;
            out_item.run_last     <= 1'b1;
            if (one_status == ST_SKIP) begin
              expected <= expected + EW'(1);
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `FPB_ALWAYS(a_expected_range, expected <= EW'(FRAME_SLOTS), "expected frame out of range")
  `FPB_ALWAYS(a_staged_range, staged <= CW'(BEATS_PER_FRAME), "staging count out of range")
  `FPB_IMPLY(a_exh_only_at_end, out_valid && out_item.status == ST_EXH, expected == EW'(FRAME_SLOTS), "exhausted reported early")
  `FPB_IMPLY(a_no_input_when_busy, state == S_CLEAR || state == S_EMIT, !in_acc, "item accepted while busy")

endmodule
